// ===== rtl/hse_pkg.sv =====
// Package for the histogram entropy block: payload types, log table, state types.
// No dependencies.
package hse_pkg;

  localparam int CNT_W = 40;
  localparam int XLX_W = 62;
  localparam int OUT_W = 20;
  localparam int LN_W  = 24;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [XLX_W-1:0] XLX_MAX = {XLX_W{1'b1}};

  typedef struct packed {
    logic [23:0] bin_count;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [19:0] entropy_nats;
    logic        empty_histogram;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_ACC, ST_LNTOT, ST_DIV, ST_FIN, ST_OUT
  } back_state_t;

  function automatic logic [15:0] lntab(input logic [4:0] k);
    case (k)
      5'd0:  lntab = 16'd0;
      5'd1:  lntab = 16'd3973;
      5'd2:  lntab = 16'd7719;
      5'd3:  lntab = 16'd11262;
      5'd4:  lntab = 16'd14624;
      5'd5:  lntab = 16'd17821;
      5'd6:  lntab = 16'd20870;
      5'd7:  lntab = 16'd23783;
      5'd8:  lntab = 16'd26573;
      5'd9:  lntab = 16'd29248;
      5'd10: lntab = 16'd31818;
      5'd11: lntab = 16'd34292;
      5'd12: lntab = 16'd36675;
      5'd13: lntab = 16'd38975;
      5'd14: lntab = 16'd41196;
      5'd15: lntab = 16'd43345;
      5'd16: lntab = 16'd45426;
      default: lntab = 16'd0;
    endcase
  endfunction

endpackage

// ===== rtl/hse_ln.sv =====
// Two-stage fixed-point natural log in Q16 for a 40-bit argument.
// Depends on hse_pkg.
module hse_ln (
  input  logic                   clk,
  input  logic                   go,
  input  logic [hse_pkg::CNT_W-1:0] n,
  output logic [hse_pkg::LN_W-1:0]  ln
);
  import hse_pkg::*;

  logic [5:0]  e;
  logic [15:0] f;
  logic [5:0]  e_q;
  logic [15:0] f_q;
  logic        nz_q;
  logic [CNT_W+15:0] wide;
  logic [15:0] lo, hi;
  logic [27:0] prod;
  logic [37:0] ep;
  logic [16:0] frac;

  always_comb begin
    e = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (n[b]) e = 6'(b);
    end
    wide = {n, 16'd0} >> e;
    f = wide[15:0];
  end

  always_ff @(posedge clk) begin
    if (go) begin
      e_q  <= e;
      f_q  <= f;
      nz_q <= (n != '0);
    end
  end

  always_comb begin
    lo   = lntab({1'b0, f_q[15:12]});
    hi   = lntab({1'b0, f_q[15:12]} + 5'd1);
    prod = 28'(hi - lo) * 28'(f_q[11:0]) + 28'd2048;
    frac = 17'(lo) + 17'(prod[27:12]);
    ep   = 38'(e_q) * 38'(LN2_Q32) + 38'd32768;
    ln   = nz_q ? (LN_W'(ep[37:16]) + LN_W'(frac)) : '0;
  end
endmodule

// ===== rtl/hse_front.sv =====
// Front end: input transfer, two-entry queue of bins toward the back end.
// Depends on hse_pkg.
module hse_front #(
  parameter int COUNT_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  hse_pkg::in_item_t in_item,
  input  logic              in_valid,
  output logic              in_ready,
  output hse_pkg::in_item_t q_item,
  output logic              q_valid,
  input  logic              q_take
);
  import hse_pkg::*;

  in_item_t  mem [2];
  logic      wp, rp;
  logic [1:0] cnt;
  in_item_t  masked;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = mem[rp];

  always_comb begin
    masked = in_item;
    masked.bin_count = in_item.bin_count & 24'((64'd1 << COUNT_BITS) - 64'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_take && q_valid) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_take && q_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= masked;
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd2) |-> !in_ready)
    else $error("ready while full");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd0) |-> !q_valid)
    else $error("queue valid while empty");
endmodule

// ===== rtl/hse_back.sv =====
// Back end: accumulates n*ln(n), then a serial divider forms the entropy.
// Depends on hse_pkg and hse_ln.
module hse_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  hse_pkg::in_item_t  q_item,
  input  logic               q_valid,
  output logic               q_take,
  output hse_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);
  import hse_pkg::*;

  back_state_t state, state_next;
  logic [CNT_W-1:0] count_total;
  logic [XLX_W-1:0] xlogx_total;
  logic [CNT_W-1:0] ln_arg;
  logic [LN_W-1:0]  ln;
  logic             phase;
  logic             last_q;
  logic [23:0]      n_q;
  logic [LN_W-1:0]  lt;
  logic [XLX_W:0]   num;
  logic [XLX_W:0]   quo;
  logic [CNT_W:0]   rem;
  logic [6:0]       bitc;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   cnt_sum;
  logic [XLX_W:0]   xsum;
  logic [47:0]      t;
  logic             go;
  logic [LN_W-1:0]  h;
  logic [OUT_W-1:0] hout;
  logic [LN_W+8:0]  hsh;

  localparam int SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 16 - FRAC_BITS;

  hse_ln u_ln (.clk(clk), .go(go), .n(ln_arg), .ln(ln));

  // Item log uses the queued bin; the total log uses the finished sum.
  assign ln_arg  = (state == ST_ACC) ? CNT_W'(q_item.bin_count) : count_total;
  assign go      = (state == ST_ACC && !phase) || (state == ST_LNTOT && !phase);
  assign q_take  = (state == ST_ACC) && q_valid && !phase;
  assign t       = 48'(n_q) * 48'(ln);
  assign cnt_sum = {1'b0, count_total} + (CNT_W+1)'(n_q);
  assign xsum    = {1'b0, xlogx_total} + (XLX_W+1)'(t);
  assign rem_sh  = {rem[CNT_W-1:0], num[XLX_W]};

  always_comb begin
    h = (quo > (XLX_W+1)'(lt)) ? '0 : lt - quo[LN_W-1:0];
    if (FRAC_BITS >= 16) hsh = (LN_W+9)'(h) << SH;
    else hsh = ((LN_W+9)'(h) + ((LN_W+9)'(1) << SH >> 1)) >> SH;
    hout = (hsh > (LN_W+9)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : hsh[OUT_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_ACC:   if (phase && last_q) state_next = ST_LNTOT;
      ST_LNTOT: if (phase) state_next = (count_total == '0) ? ST_OUT : ST_DIV;
      ST_DIV:   if (bitc == 7'd0) state_next = ST_FIN;
      ST_FIN:   state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_ACC;
      default:  state_next = ST_ACC;
    endcase
  end

  always_comb begin
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC; phase <= 1'b0;
      count_total <= '0; xlogx_total <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_ACC: begin
          if (q_take) begin
            phase <= 1'b1; n_q <= q_item.bin_count; last_q <= q_item.is_last;
          end else if (phase) begin
            phase <= 1'b0;
            count_total <= cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
            xlogx_total <= xsum[XLX_W] ? XLX_MAX : xsum[XLX_W-1:0];
          end
        end
        ST_LNTOT: begin
          phase <= ~phase;
          if (phase) begin
            lt   <= ln;
            num  <= {1'b0, xlogx_total} + (XLX_W+1)'(count_total >> 1);
            rem  <= '0;
            bitc <= 7'(XLX_W + 1);
            out_item.entropy_nats    <= '0;
            out_item.empty_histogram <= (count_total == '0);
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (bitc != 7'd0) begin
            if (rem_sh >= {1'b0, count_total}) begin
              rem <= rem_sh - {1'b0, count_total};
              quo <= {quo[XLX_W-1:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[XLX_W-1:0], 1'b0};
            end
            num  <= num << 1;
            bitc <= bitc - 7'd1;
          end
        end
        ST_FIN: out_item.entropy_nats <= hout;
        ST_OUT: if (out_ready) begin
          count_total <= '0; xlogx_total <= '0;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !q_take)
    else $error("bin taken during result transfer");
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_DIV) |-> (count_total != '0))
    else $error("divide by zero total");
endmodule

// ===== rtl/histogram_shannon_entropy.sv =====
// Top level of the streaming histogram entropy block.
// Depends on hse_pkg, hse_front, hse_back.
// Bins arrive one per transfer; each nonzero bin adds n and n*ln(n) to running
// sums. A bin passes through the two-stage log unit before the back end takes
// the next one, and a two-entry queue lets the input side keep moving. On the
// last bin the block takes the log of the total, runs a restoring divider one
// bit per cycle (63 quotient bits), rounds, and presents ln(total) - sum/total
// with FRAC_BITS fraction bits. An all-zero histogram skips the divider and
// gives zero with the empty flag set. The back end takes no further bins until
// the result transfer completes.
module histogram_shannon_entropy #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  hse_pkg::in_item_t  in_item,
  input  logic               in_valid,
  output logic               in_ready,
  output hse_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);
  import hse_pkg::*;

  in_item_t q_item;
  logic     q_valid, q_take;

  hse_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .in_valid(in_valid),
    .in_ready(in_ready), .q_item(q_item), .q_valid(q_valid), .q_take(q_take)
  );

  hse_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_item(q_item), .q_valid(q_valid), .q_take(q_take),
    .out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
  );
endmodule
